// ===== rtl/core/percent_decoder_defines.svh =====
// assertion macros for the percent decoder
`ifndef PERCENT_DECODER_DEFINES_SVH
`define PERCENT_DECODER_DEFINES_SVH

`ifndef SYNTHESIS

// same-cycle implication, sampled on i_clk, off while i_rst_n is low
`define PD_ASSERT_IMPL(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, sampled on i_clk, off while i_rst_n is low
`define PD_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`else

`define PD_ASSERT_IMPL(lbl, ante, cons, msg)

`define PD_ASSERT_NEXT(lbl, ante, cons, msg)

`endif

`endif

// ===== rtl/core/pd_pkg.sv =====
// shared types, constants and helpers of the percent decoder
package pd_pkg;

    localparam int BYTE_W    = 8;
    localparam int QUEUE_DEF = 4;

    localparam logic [BYTE_W-1:0] PCT_CHAR   = 8'h25;
    localparam logic [BYTE_W-1:0] PLUS_CHAR  = 8'h2B;
    localparam logic [BYTE_W-1:0] SPACE_CHAR = 8'h20;

    // held escape state
    localparam logic [1:0] HELD_NONE  = 2'd0;
    localparam logic [1:0] HELD_PCT   = 2'd1;
    localparam logic [1:0] HELD_DIGIT = 2'd2;

    // one classified input byte: up to three output bytes
    typedef struct packed {
        logic              last;
        logic [1:0]        count;
        logic [BYTE_W-1:0] byte2;
        logic [BYTE_W-1:0] byte1;
        logic [BYTE_W-1:0] byte0;
    } t_cmd;

    // hex digit decode: bit 4 set when the character is a hex digit
    function automatic logic [4:0] hex_value(input logic [BYTE_W-1:0] c);
        logic [4:0] r;
        r = 5'd0;
        if (c >= 8'h30 && c <= 8'h39) begin
            r = {1'b1, 4'(c - 8'h30)};
        end else if (c >= 8'h41 && c <= 8'h46) begin
            r = {1'b1, 4'(c - 8'h37)};
        end else if (c >= 8'h61 && c <= 8'h66) begin
            r = {1'b1, 4'(c - 8'h57)};
        end
        return r;
    endfunction

endpackage

// ===== rtl/core/pd_if.sv =====
// handshake channels of the percent decoder
interface pd_in_if;
    import pd_pkg::*;
    logic              valid;
    logic              ready;
    logic [BYTE_W-1:0] in_byte;
    logic              in_last;
    modport source (output valid, output in_byte, output in_last, input ready);
    modport sink   (input valid, input in_byte, input in_last, output ready);
endinterface

interface pd_out_if;
    import pd_pkg::*;
    logic              valid;
    logic              ready;
    logic [BYTE_W-1:0] out_byte;
    logic              out_last;
    modport source (output valid, output out_byte, output out_last, input ready);
    modport sink   (input valid, input out_byte, input out_last, output ready);
endinterface

interface pd_cfg_if;
    logic valid;
    logic ready;
    logic plus_as_space;
    modport source (output valid, output plus_as_space, input ready);
    modport sink   (input valid, input plus_as_space, output ready);
endinterface

// ===== rtl/core/pd_front.sv =====
// front end: accepts bytes, tracks held escapes, builds output commands
module pd_front
    import pd_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    pd_in_if.sink      i_in,
    pd_cfg_if.sink     i_cfg,
    input  logic       i_full,
    output logic       o_push,
    output t_cmd       o_cmd
);

    logic              r_plus;
    logic [1:0]        r_held_count;
    logic [1:0]        n_held_count;
    logic [BYTE_W-1:0] r_held_digit;
    logic [BYTE_W-1:0] n_held_digit;

    logic              w_take;
    logic [BYTE_W-1:0] w_b;
    logic [4:0]        w_hex_b;
    logic [4:0]        w_hex_d;
    logic [BYTE_W-1:0] w_o [4];
    logic [2:0]        w_n;

    assign i_cfg.ready = 1'b1;
    assign i_in.ready  = !i_full;
    assign w_take      = i_in.valid && !i_full;

    // plus mapping on raw bytes only
    assign w_b     = (r_plus && i_in.in_byte == PLUS_CHAR) ? SPACE_CHAR : i_in.in_byte;
    assign w_hex_b = hex_value(w_b);
    assign w_hex_d = hex_value(r_held_digit);

    // classify the byte against the held state, list output bytes in order
    always_comb begin
        w_o[0]       = '0;
        w_o[1]       = '0;
        w_o[2]       = '0;
        w_o[3]       = '0;
        w_n          = 3'd0;
        n_held_count = HELD_NONE;
        n_held_digit = r_held_digit;
        unique case (r_held_count)
            HELD_PCT: begin
                if (w_hex_b[4]) begin
                    n_held_count = HELD_DIGIT;
                    n_held_digit = w_b;
                end else begin
                    w_o[w_n[1:0]] = PCT_CHAR;
                    w_n = w_n + 3'd1;
                    if (w_b == PCT_CHAR) begin
                        n_held_count = HELD_PCT;
                    end else begin
                        w_o[w_n[1:0]] = w_b;
                        w_n = w_n + 3'd1;
                    end
                end
            end
            HELD_DIGIT: begin
                if (w_hex_b[4]) begin
                    w_o[w_n[1:0]] = {w_hex_d[3:0], w_hex_b[3:0]};
                    w_n = w_n + 3'd1;
                end else begin
                    w_o[w_n[1:0]] = PCT_CHAR;
                    w_n = w_n + 3'd1;
                    w_o[w_n[1:0]] = r_held_digit;
                    w_n = w_n + 3'd1;
                    if (w_b == PCT_CHAR) begin
                        n_held_count = HELD_PCT;
                    end else begin
                        w_o[w_n[1:0]] = w_b;
                        w_n = w_n + 3'd1;
                    end
                end
            end
            default: begin
                if (w_b == PCT_CHAR) begin
                    n_held_count = HELD_PCT;
                end else begin
                    w_o[w_n[1:0]] = w_b;
                    w_n = w_n + 3'd1;
                end
            end
        endcase
        // flush whatever is held at the end of the string
        if (i_in.in_last) begin
            if (n_held_count == HELD_PCT || n_held_count == HELD_DIGIT) begin
                w_o[w_n[1:0]] = PCT_CHAR;
                w_n = w_n + 3'd1;
            end
            if (n_held_count == HELD_DIGIT) begin
                w_o[w_n[1:0]] = n_held_digit;
                w_n = w_n + 3'd1;
            end
            n_held_count = HELD_NONE;
        end
    end

    // at most three bytes leave per input byte
    assign o_cmd.byte0 = w_o[0];
    assign o_cmd.byte1 = w_o[1];
    assign o_cmd.byte2 = w_o[2];
    assign o_cmd.count = (w_n > 3'd3) ? 2'd3 : w_n[1:0];
    assign o_cmd.last  = i_in.in_last;
    assign o_push      = w_take && (w_n != 3'd0);

    // mode register and held escape state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_plus       <= 1'b0;
            r_held_count <= HELD_NONE;
            r_held_digit <= '0;
        end else begin
            if (i_cfg.valid) begin
                r_plus <= i_cfg.plus_as_space;
            end
            if (w_take) begin
                r_held_count <= n_held_count;
                r_held_digit <= n_held_digit;
            end
        end
    end

endmodule

// ===== rtl/core/pd_queue.sv =====
// command queue between front and back end
module pd_queue
    import pd_pkg::*;
#(
    parameter int DEPTH = QUEUE_DEF
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_cmd i_cmd,
    input  logic i_pop,
    output t_cmd o_cmd,
    output logic o_full,
    output logic o_empty
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    t_cmd             r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr;
    logic [PTR_W-1:0] r_rd;
    logic [CNT_W-1:0] r_cnt;

    assign o_full  = (r_cnt == CNT_W'(DEPTH));
    assign o_empty = (r_cnt == '0);
    assign o_cmd   = r_mem[r_rd];

    // entry storage
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_cmd;
        end
    end

    // pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wr <= (r_wr == PTR_W'(DEPTH - 1)) ? '0 : r_wr + PTR_W'(1);
            end
            if (i_pop) begin
                r_rd <= (r_rd == PTR_W'(DEPTH - 1)) ? '0 : r_rd + PTR_W'(1);
            end
            if (i_push && !i_pop) begin
                r_cnt <= r_cnt + CNT_W'(1);
            end else if (i_pop && !i_push) begin
                r_cnt <= r_cnt - CNT_W'(1);
            end
        end
    end

endmodule

// ===== rtl/core/pd_back.sv =====
// back end: plays out the bytes of each command, one per transfer
module pd_back
    import pd_pkg::*;
(
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  t_cmd   i_cmd,
    input  logic   i_empty,
    output logic   o_pop,
    pd_out_if.source o_out
);

    t_cmd       r_cmd;
    logic       r_busy;
    logic [1:0] r_idx;
    logic       w_take;
    logic       w_end;

    assign w_take = r_busy && o_out.ready;
    assign w_end  = (r_idx == r_cmd.count - 2'd1);
    assign o_pop  = !i_empty && (!r_busy || (w_take && w_end));

    // output byte selection from the held command
    assign o_out.valid    = r_busy;
    assign o_out.out_last = r_cmd.last && w_end;
    always_comb begin
        unique case (r_idx)
            2'd0:    o_out.out_byte = r_cmd.byte0;
            2'd1:    o_out.out_byte = r_cmd.byte1;
            default: o_out.out_byte = r_cmd.byte2;
        endcase
    end

    // command register
    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_cmd <= i_cmd;
        end
    end

    // play-out control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_idx  <= 2'd0;
        end else if (o_pop) begin
            r_busy <= 1'b1;
            r_idx  <= 2'd0;
        end else if (w_take && w_end) begin
            r_busy <= 1'b0;
        end else if (w_take) begin
            r_idx <= r_idx + 2'd1;
        end
    end

endmodule

// ===== rtl/core/percent_decoder.sv =====
// top level of the streaming url percent decoder
// Streaming percent-escape decoder: one encoded byte can be taken every cycle on i_in and
// decoded bytes leave on o_out at up to one per cycle. A byte that breaks an escape or ends
// a string may give two or three output bytes, which the back end plays out one by one;
// a command queue of QUEUE_DEPTH entries between the classifying front end and the
// play-out back end lets input keep flowing meanwhile, and input stalls only when that
// queue is full. With the queue and back end idle, the first byte caused by an input
// transfer is written into the queue, then loaded into the back end's command register,
// and is then valid on o_out.
// i_cfg sets plus_as_space, which maps raw '+' to space; it is always ready.
`include "percent_decoder_defines.svh"

module percent_decoder
    import pd_pkg::*;
#(
    parameter int QUEUE_DEPTH = QUEUE_DEF
) (
    input  logic     i_clk,
    input  logic     i_rst_n,
    pd_in_if.sink    i_in,
    pd_cfg_if.sink   i_cfg,
    pd_out_if.source o_out
);

    t_cmd w_push_cmd;
    t_cmd w_head_cmd;
    logic w_push;
    logic w_pop;
    logic w_full;
    logic w_empty;

    // byte classification
    pd_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (i_in),
        .i_cfg   (i_cfg),
        .i_full  (w_full),
        .o_push  (w_push),
        .o_cmd   (w_push_cmd)
    );

    // command queue
    pd_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_cmd   (w_push_cmd),
        .i_pop   (w_pop),
        .o_cmd   (w_head_cmd),
        .o_full  (w_full),
        .o_empty (w_empty)
    );

    // output play-out
    pd_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (w_head_cmd),
        .i_empty (w_empty),
        .o_pop   (w_pop),
        .o_out   (o_out)
    );

    // checks
    `PD_ASSERT_IMPL(a_push_room, w_push, !w_full, "push into a full queue")
    `PD_ASSERT_IMPL(a_pop_data, w_pop, !w_empty, "pop from an empty queue")
    `PD_ASSERT_IMPL(a_last_out, i_in.valid && i_in.ready && i_in.in_last, w_push, "no flush")
    `PD_ASSERT_NEXT(a_push_seen, w_push, !w_empty, "pushed command not in queue")

endmodule

// ===== bench/percent_decode_checker.sv =====
// scoreboard for the percent decoder: predicts decoded bytes and compares output transfers
`timescale 1ns / 1ps

module percent_decode_checker
    import pd_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    input  logic              i_in_ready,
    input  logic [BYTE_W-1:0] i_in_byte,
    input  logic              i_in_last,
    input  logic              i_cfg_valid,
    input  logic              i_cfg_ready,
    input  logic              i_cfg_plus,
    input  logic              i_out_valid,
    input  logic              i_out_ready,
    input  logic [BYTE_W-1:0] i_out_byte,
    input  logic              i_out_last,
    output int                o_pending,
    output int                o_fail_count
);

    typedef struct packed {
        logic [BYTE_W-1:0] data;
        logic              last;
    } t_decoded;

    // bytes still owed by the decoder, oldest first
    t_decoded          decoded_q[$];
    logic              plus_mode;
    logic [1:0]        esc_held;
    logic [BYTE_W-1:0] esc_digit;
    int                fails = 0;

    // bit 4 flags a hex digit, bits 3:0 carry its value
    function automatic logic [4:0] nibble_of(input logic [BYTE_W-1:0] c);
        if (c >= "0" && c <= "9") begin
            return {1'b1, c[3:0]};
        end
        if ((c >= "A" && c <= "F") || (c >= "a" && c <= "f")) begin
            return {1'b1, c[3:0] + 4'd9};
        end
        return 5'd0;
    endfunction

    // append one owed byte at the tail
    task automatic emit(input logic [BYTE_W-1:0] b);
        t_decoded e;
        e.data    = b;
        e.last    = 1'b0;
        decoded_q = {decoded_q, e};
    endtask

    // nothing held: a percent sign opens an escape, anything else passes
    task automatic open_or_pass(input logic [BYTE_W-1:0] b);
        if (b == PCT_CHAR) begin
            esc_held = HELD_PCT;
        end else begin
            emit(b);
        end
    endtask

    // expected output of one accepted input byte
    task automatic decode_step(input logic [BYTE_W-1:0] raw, input logic last);
        logic [BYTE_W-1:0] b;
        logic [4:0]        lo;
        logic [4:0]        hi;
        int                first;
        t_decoded          tail;
        first = decoded_q.size();
        b     = (plus_mode && raw == PLUS_CHAR) ? SPACE_CHAR : raw;
        lo    = nibble_of(b);
        case (esc_held)
            HELD_PCT: begin
                if (lo[4]) begin
                    esc_digit = b;
                    esc_held  = HELD_DIGIT;
                end else begin
                    emit(PCT_CHAR);
                    esc_held = HELD_NONE;
                    open_or_pass(b);
                end
            end
            HELD_DIGIT: begin
                hi       = nibble_of(esc_digit);
                esc_held = HELD_NONE;
                if (lo[4]) begin
                    emit({hi[3:0], lo[3:0]});
                end else begin
                    emit(PCT_CHAR);
                    emit(esc_digit);
                    open_or_pass(b);
                end
            end
            default: begin
                esc_held = HELD_NONE;
                open_or_pass(b);
            end
        endcase
        // end of string flushes whatever is held and tags the final byte
        if (last) begin
            if (esc_held != HELD_NONE) begin
                emit(PCT_CHAR);
            end
            if (esc_held == HELD_DIGIT) begin
                emit(esc_digit);
            end
            esc_held = HELD_NONE;
            if (decoded_q.size() > first) begin
                tail      = decoded_q.pop_back();
                tail.last = 1'b1;
                decoded_q = {decoded_q, tail};
            end
        end
    endtask

    // watch every transfer on the three channels
    always @(posedge i_clk) begin
        t_decoded want;
        if (!i_rst_n) begin
            plus_mode = 1'b0;
            esc_held  = HELD_NONE;
            esc_digit = '0;
            decoded_q.delete();
        end else begin
            if (i_in_valid && i_in_ready) begin
                decode_step(i_in_byte, i_in_last);
            end
            if (i_cfg_valid && i_cfg_ready) begin
                plus_mode = i_cfg_plus;
            end
            if (i_out_valid && i_out_ready) begin
                if (decoded_q.size() == 0) begin
                    fails++;
                    $display("%0t: unexpected output byte %02h last %0b",
                             $time, i_out_byte, i_out_last);
                end else begin
                    want = decoded_q.pop_front();
                    if (want.data !== i_out_byte || want.last !== i_out_last) begin
                        fails++;
                        if (want.data !== i_out_byte) begin
                            $display("%0t: out_byte expected %02h actual %02h",
                                     $time, want.data, i_out_byte);
                        end
                        if (want.last !== i_out_last) begin
                            $display("%0t: out_last expected %0b actual %0b",
                                     $time, want.last, i_out_last);
                        end
                    end
                end
            end
        end
        o_pending    <= decoded_q.size();
        o_fail_count <= fails;
    end

endmodule

// ===== bench/tb_percent_decoder.sv =====
// testbench top of the percent decoder: clock, reset, stimulus and verdict
`timescale 1ns / 1ps

module tb_percent_decoder;
    import pd_pkg::*;

    localparam int PHASES      = 10;
    localparam int PHASE_ITEMS = 50;
    localparam int DRAIN       = 6;
    localparam int HOLD_CYCLES = 80;
    localparam int MAX_CYCLES  = 200000;

    logic i_clk;
    logic i_rst_n;
    int   cycle_count = 0;
    int   pending;
    int   fail_count;
    int   items_sent  = 0;
    bit   idle_en     = 1'b1;
    bit   hold_req    = 1'b0;

    pd_in_if  in_ch ();
    pd_cfg_if cfg_ch ();
    pd_out_if out_ch ();

    percent_decoder u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .i_cfg   (cfg_ch),
        .o_out   (out_ch)
    );

    percent_decode_checker u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (in_ch.valid),
        .i_in_ready   (in_ch.ready),
        .i_in_byte    (in_ch.in_byte),
        .i_in_last    (in_ch.in_last),
        .i_cfg_valid  (cfg_ch.valid),
        .i_cfg_ready  (cfg_ch.ready),
        .i_cfg_plus   (cfg_ch.plus_as_space),
        .i_out_valid  (out_ch.valid),
        .i_out_ready  (out_ch.ready),
        .i_out_byte   (out_ch.out_byte),
        .i_out_last   (out_ch.out_last),
        .o_pending    (pending),
        .o_fail_count (fail_count)
    );

    // clock
    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    // run limit
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= MAX_CYCLES) begin
            $display("[percent_decoder] ERROR");
            $finish;
        end
    end

    // offer one byte, after a random gap when idle_en is set, and hold it until the transfer
    task automatic send_byte(input logic [BYTE_W-1:0] b, input logic last);
        int gap;
        gap = idle_en ? $urandom_range(0, 5) : 0;
        if (gap > 0) begin
            in_ch.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        in_ch.valid   <= 1'b1;
        in_ch.in_byte <= b;
        in_ch.in_last <= last;
        do @(posedge i_clk); while (!in_ch.ready);
        items_sent++;
    endtask

    task automatic send_text(input string s, input logic last);
        for (int i = 0; i < s.len(); i++) begin
            send_byte(s[i], last && (i == s.len() - 1));
        end
    endtask

    // given byte with an occasional end of string
    task automatic feed_byte(input logic [BYTE_W-1:0] b);
        send_byte(b, $urandom_range(0, 9) == 0);
    endtask

    function automatic logic [BYTE_W-1:0] hex_char();
        int r;
        r = $urandom_range(0, 21);
        if (r < 10) begin
            return BYTE_W'("0" + r);
        end
        if (r < 16) begin
            return BYTE_W'("A" + r - 10);
        end
        return BYTE_W'("a" + r - 16);
    endfunction

    // any byte that is not a hex digit
    function automatic logic [BYTE_W-1:0] other_char();
        case ($urandom_range(0, 4))
            0:       return BYTE_W'($urandom_range(8'h00, 8'h2F));
            1:       return BYTE_W'($urandom_range(8'h3A, 8'h40));
            2:       return BYTE_W'($urandom_range(8'h47, 8'h60));
            3:       return BYTE_W'($urandom_range(8'h67, 8'hFF));
            default: return PLUS_CHAR;
        endcase
    endfunction

    // well-formed escapes as the most common token, with plain bytes, plus signs and broken escapes
    task automatic send_token();
        int kind;
        kind = $urandom_range(0, 19);
        if (kind < 9) begin
            feed_byte(PCT_CHAR);
            feed_byte(hex_char());
            feed_byte(hex_char());
        end else if (kind < 14) begin
            feed_byte(BYTE_W'($urandom_range(0, 255)));
        end else if (kind < 16) begin
            feed_byte(PLUS_CHAR);
        end else if (kind < 18) begin
            feed_byte(PCT_CHAR);
            feed_byte(hex_char());
            feed_byte(other_char());
        end else begin
            feed_byte(PCT_CHAR);
            feed_byte(other_char());
        end
    endtask

    // stop offering and wait until every owed byte has come out
    task automatic drain_outputs();
        in_ch.valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (DRAIN) @(posedge i_clk);
    endtask

    task automatic write_mode(input logic mode);
        drain_outputs();
        cfg_ch.valid         <= 1'b1;
        cfg_ch.plus_as_space <= mode;
        do @(posedge i_clk); while (!cfg_ch.ready);
        cfg_ch.valid <= 1'b0;
    endtask

    // output side: random stalls, one long hold-off on request
    initial begin : sink_side
        int w;
        out_ch.ready <= 1'b0;
        do @(posedge i_clk); while (!i_rst_n);
        forever begin
            if (hold_req) begin
                hold_req = 1'b0;
                out_ch.ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge i_clk);
            end
            w = idle_en ? $urandom_range(0, 5) : 0;
            if (w > 0) begin
                out_ch.ready <= 1'b0;
                repeat (w) @(posedge i_clk);
            end
            out_ch.ready <= 1'b1;
            do @(posedge i_clk); while (!out_ch.valid);
        end
    end

    // input side: reset, directed strings, random phases, verdict
    initial begin : source_side
        int phase_start;
        i_rst_n              <= 1'b0;
        in_ch.valid          <= 1'b0;
        in_ch.in_byte        <= '0;
        in_ch.in_last        <= 1'b0;
        cfg_ch.valid         <= 1'b0;
        cfg_ch.plus_as_space <= 1'b0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // decimal and lower case hex digits, broken escapes, flushes, byte extremes
        send_text("%41", 1'b0);
        send_text("%6f", 1'b1);
        send_text("%%25", 1'b0);
        send_byte(8'h00, 1'b0);
        send_byte(8'hFF, 1'b1);
        send_text("%4", 1'b1);
        send_text("%", 1'b1);
        send_text("+", 1'b0);

        // plus mapping, escaped plus untouched, three bytes from one input
        write_mode(1'b1);
        send_text("+%2B", 1'b1);
        send_text("%A+", 1'b1);

        // mode change while a percent sign is held
        send_text("%", 1'b0);
        write_mode(1'b0);
        send_text("+", 1'b1);

        // random phases, each under its own mode and idling
        for (int p = 0; p < PHASES; p++) begin
            write_mode(p == 0 ? 1'b0 : (p == 1 ? 1'b1 : 1'($urandom_range(0, 1))));
            idle_en = ($urandom_range(0, 3) != 0);
            if (p == 2) begin
                idle_en  = 1'b0;
                hold_req = 1'b1;
            end
            phase_start = items_sent;
            while (items_sent - phase_start < PHASE_ITEMS) begin
                send_token();
            end
        end

        drain_outputs();
        if (fail_count == 0) begin
            $display("[percent_decoder] OK");
        end else begin
            $display("[percent_decoder] ERROR");
        end
        $finish;
    end

endmodule

// ===== files.f =====
+incdir+rtl/core
rtl/core/pd_pkg.sv
rtl/core/pd_if.sv
rtl/core/pd_front.sv
rtl/core/pd_queue.sv
rtl/core/pd_back.sv
rtl/core/percent_decoder.sv
bench/percent_decode_checker.sv
bench/tb_percent_decoder.sv
